// File: rtl/flow_timing_statistics_core_defines.svh
// Assertion helpers for the flow timing statistics core.
`ifndef FLOW_TIMING_STATISTICS_CORE_DEFINES_SVH
`define FLOW_TIMING_STATISTICS_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled in reset.
`define FTS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define FTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define FTS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define FTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: rtl/fts_pkg.sv
`default_nettype none

package fts_pkg;

    localparam int DIV_STEPS = 64;
    localparam int SQRT_STEPS = 32;
    localparam logic [31:0] FRAC_MAX = 32'hFFFF_FFFF;

    // one divider lane: partial remainder and dividend/quotient shift word
    typedef struct packed {
        logic [31:0] rem;
        logic [63:0] q;
    } t_ds32;

    typedef struct packed {
        logic [47:0] rem;
        logic [63:0] q;
    } t_ds48;

    typedef struct packed {
        t_ds32       gap_mean;
        t_ds32       gap_sq;
        t_ds32       idle_avg;
        t_ds48       frac;
        logic [31:0] gap_cnt;
        logic [31:0] idle_cnt;
        logic [47:0] dur_div;
        logic [48:0] dur;
        logic        dur_pos;
    } t_div_st;

    typedef struct packed {
        logic [47:0] mean;
        logic [47:0] imean;
        logic [31:0] frac;
        logic [48:0] dur;
        logic        gap_zero;
    } t_side;

    typedef struct packed {
        logic [63:0] x;
        logic [63:0] res;
        t_side       side;
    } t_sq_st;

    function automatic t_ds32 div_step32(t_ds32 s, logic [31:0] d);
        logic [32:0] t;
        t_ds32       r;
        t = {s.rem, s.q[63]};
        r.q = {s.q[62:0], 1'b0};
        if (t >= {1'b0, d}) begin
            r.rem = 32'(t - {1'b0, d});
            r.q[0] = 1'b1;
        end else begin
            r.rem = t[31:0];
        end
        return r;
    endfunction

    function automatic t_ds48 div_step48(t_ds48 s, logic [47:0] d);
        logic [48:0] t;
        t_ds48       r;
        t = {s.rem, s.q[63]};
        r.q = {s.q[62:0], 1'b0};
        if (t >= {1'b0, d}) begin
            r.rem = 48'(t - {1'b0, d});
            r.q[0] = 1'b1;
        end else begin
            r.rem = t[47:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/flow_timing_statistics_core.sv
// Flow timing statistics core. Each accepted word is one flow record's
// timing counters; exactly one result word comes back per record, in
// order: duration, floor mean gap, floor gap standard deviation, floor
// mean idle period and idle fraction (Q16.16, saturating). Throughput is
// one record per cycle while o_stall is low. Each word passes one load
// stage, 64 restoring-divide stages (one quotient bit per stage, four
// dividers side by side), a 32x32 square stage, a variance subtract
// stage, 32 square-root stages (one result bit each) and the output
// register. The whole pipe advances together; o_stall rises only while
// a finished word sits in the output register under i_stall.
`default_nettype none

`include "flow_timing_statistics_core_defines.svh"

module flow_timing_statistics_core
    import fts_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [47:0] i_first_seen_us,
    input  wire logic [47:0] i_last_seen_us,
    input  wire logic [31:0] i_gap_count,
    input  wire logic [47:0] i_gap_sum_us,
    input  wire logic [63:0] i_gap_square_sum,
    input  wire logic [31:0] i_idle_count,
    input  wire logic [47:0] i_idle_total_us,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic signed [48:0] o_duration_us,
    output logic [47:0]      o_mean_gap_us,
    output logic [31:0]      o_gap_std_us,
    output logic [47:0]      o_idle_mean_us,
    output logic [31:0]      o_idle_fraction
);

    logic    adv;        // whole pipe moves this cycle
    t_div_st r_div [0:DIV_STEPS];
    logic    r_div_vld [0:DIV_STEPS];

    t_side       r_mul_side;
    logic [63:0] r_mul_m2;
    logic [63:0] r_mul_q;
    logic        r_mul_big;
    logic        r_mul_vld;

    t_sq_st r_sq [0:SQRT_STEPS];
    logic   r_sq_vld [0:SQRT_STEPS];

    logic r_out_vld;

    assign adv = !(r_out_vld && i_stall);
    assign o_stall = !adv;
    assign o_valid = r_out_vld;

    // load stage: dividends in the shift words, remainders cleared
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_vld[0] <= 1'b0;
        end else if (adv) begin
            r_div_vld[0] <= i_valid;
        end
        if (adv) begin
            r_div[0].gap_mean.rem  <= '0;
            r_div[0].gap_mean.q    <= {16'd0, i_gap_sum_us};
            r_div[0].gap_sq.rem    <= '0;
            r_div[0].gap_sq.q      <= i_gap_square_sum;
            r_div[0].idle_avg.rem  <= '0;
            r_div[0].idle_avg.q    <= {16'd0, i_idle_total_us};
            r_div[0].frac.rem      <= '0;
            r_div[0].frac.q        <= {i_idle_total_us, 16'd0};
            r_div[0].gap_cnt       <= i_gap_count;
            r_div[0].idle_cnt      <= i_idle_count;
            r_div[0].dur_div       <= 48'(i_last_seen_us - i_first_seen_us);
            r_div[0].dur           <= {1'b0, i_last_seen_us} - {1'b0, i_first_seen_us};
            r_div[0].dur_pos       <= i_last_seen_us > i_first_seen_us;
        end
    end

    // divide stages: one quotient bit per stage for all four dividers
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_div_vld[k+1] <= 1'b0;
            end else if (adv) begin
                r_div_vld[k+1] <= r_div_vld[k];
            end
            if (adv) begin
                r_div[k+1].gap_cnt  <= r_div[k].gap_cnt;
                r_div[k+1].idle_cnt <= r_div[k].idle_cnt;
                r_div[k+1].dur_div  <= r_div[k].dur_div;
                r_div[k+1].dur      <= r_div[k].dur;
                r_div[k+1].dur_pos  <= r_div[k].dur_pos;
                r_div[k+1].gap_mean <= div_step32(r_div[k].gap_mean, r_div[k].gap_cnt);
                r_div[k+1].gap_sq <= div_step32(r_div[k].gap_sq, r_div[k].gap_cnt);
                r_div[k+1].idle_avg <= div_step32(r_div[k].idle_avg, r_div[k].idle_cnt);
                r_div[k+1].frac <= div_step48(r_div[k].frac, r_div[k].dur_div);
            end
        end
    end

    // square of the mean, zero-count and saturation fixups
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_vld <= 1'b0;
        end else if (adv) begin
            r_mul_vld <= r_div_vld[DIV_STEPS];
        end
        if (adv) begin
            r_mul_side.gap_zero <= r_div[DIV_STEPS].gap_cnt == '0;
            r_mul_side.mean <= (r_div[DIV_STEPS].gap_cnt == '0) ? '0
                               : r_div[DIV_STEPS].gap_mean.q[47:0];
            r_mul_side.imean <= (r_div[DIV_STEPS].idle_cnt == '0) ? '0
                                : r_div[DIV_STEPS].idle_avg.q[47:0];
            if (!r_div[DIV_STEPS].dur_pos) begin
                r_mul_side.frac <= '0;
            end else if (|r_div[DIV_STEPS].frac.q[63:32]) begin
                r_mul_side.frac <= FRAC_MAX;
            end else begin
                r_mul_side.frac <= r_div[DIV_STEPS].frac.q[31:0];
            end
            r_mul_side.dur <= r_div[DIV_STEPS].dur;
            r_mul_big <= |r_div[DIV_STEPS].gap_mean.q[63:32];
            r_mul_m2 <= r_div[DIV_STEPS].gap_mean.q[31:0]
                        * r_div[DIV_STEPS].gap_mean.q[31:0];
            r_mul_q <= r_div[DIV_STEPS].gap_sq.q;
        end
    end

    // variance, clamped at zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld[0] <= 1'b0;
        end else if (adv) begin
            r_sq_vld[0] <= r_mul_vld;
        end
        if (adv) begin
            r_sq[0].side <= r_mul_side;
            r_sq[0].res <= '0;
            if (!r_mul_side.gap_zero && !r_mul_big && (r_mul_q > r_mul_m2)) begin
                r_sq[0].x <= r_mul_q - r_mul_m2;
            end else begin
                r_sq[0].x <= '0;
            end
        end
    end

    // square root: one result bit per stage
    for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_sqrt
        localparam logic [63:0] SQ_BIT = 64'd1 << (62 - 2 * s);
        logic [63:0] trial;
        assign trial = r_sq[s].res + SQ_BIT;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_vld[s+1] <= 1'b0;
            end else if (adv) begin
                r_sq_vld[s+1] <= r_sq_vld[s];
            end
            if (adv) begin
                r_sq[s+1].side <= r_sq[s].side;
                if (r_sq[s].x >= trial) begin
                    r_sq[s+1].x <= r_sq[s].x - trial;
                    r_sq[s+1].res <= (r_sq[s].res >> 1) + SQ_BIT;
                end else begin
                    r_sq[s+1].x <= r_sq[s].x;
                    r_sq[s+1].res <= r_sq[s].res >> 1;
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= r_sq_vld[SQRT_STEPS];
        end
        if (adv) begin
            o_duration_us   <= r_sq[SQRT_STEPS].side.dur;
            o_mean_gap_us   <= r_sq[SQRT_STEPS].side.mean;
            o_gap_std_us    <= r_sq[SQRT_STEPS].res[31:0];
            o_idle_mean_us  <= r_sq[SQRT_STEPS].side.imean;
            o_idle_fraction <= r_sq[SQRT_STEPS].side.frac;
        end
    end

    `FTS_ASSERT_IMPL(a_stall_blocks, i_clk, i_rst_n, r_out_vld && i_stall, o_stall, "held word must stall input")
    `FTS_ASSERT_NEXT(a_no_gaps_zero, i_clk, i_rst_n, adv && r_sq_vld[SQRT_STEPS] && r_sq[SQRT_STEPS].side.gap_zero, o_mean_gap_us == '0 && o_gap_std_us == '0, "zero gap count must give zero stats")
    `FTS_ASSERT_IMPL(a_neg_dur_frac, i_clk, i_rst_n, o_valid && o_duration_us[48], o_idle_fraction == '0, "negative duration must give zero fraction")

endmodule

`default_nettype wire

// File: test/flow_timing_statistics_core_tb.sv
`default_nettype none

module flow_timing_statistics_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // one flow record as presented on the input ports
    typedef struct {
        logic [47:0] first;
        logic [47:0] last;
        logic [31:0] gcnt;
        logic [47:0] gsum;
        logic [63:0] gsq;
        logic [31:0] icnt;
        logic [47:0] itot;
    } t_flow_rec;

    // one result word
    typedef struct {
        logic [48:0] dur;
        logic [47:0] mean;
        logic [31:0] stdv;
        logic [47:0] imean;
        logic [31:0] frac;
    } t_flow_stats;

    // directed row: typed result used only when has_exp is set
    typedef struct {
        t_flow_rec   rec;
        logic        has_exp;
        t_flow_stats exp;
    } t_stim_row;

    localparam int N_RANDOM   = 630;
    localparam int PIPE_DRAIN = 120;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    logic [47:0] i_first_seen_us = '0;
    logic [47:0] i_last_seen_us = '0;
    logic [31:0] i_gap_count = '0;
    logic [47:0] i_gap_sum_us = '0;
    logic [63:0] i_gap_square_sum = '0;
    logic [31:0] i_idle_count = '0;
    logic [47:0] i_idle_total_us = '0;

    logic               o_stall;
    logic               o_valid;
    logic signed [48:0] o_duration_us;
    logic [47:0]        o_mean_gap_us;
    logic [31:0]        o_gap_std_us;
    logic [47:0]        o_idle_mean_us;
    logic [31:0]        o_idle_fraction;

    t_flow_stats pending_stats[$];
    int          n_errors = 0;
    int          n_results = 0;
    bit          sender_done = 1'b0;

    flow_timing_statistics_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_first_seen_us  (i_first_seen_us),
        .i_last_seen_us   (i_last_seen_us),
        .i_gap_count      (i_gap_count),
        .i_gap_sum_us     (i_gap_sum_us),
        .i_gap_square_sum (i_gap_square_sum),
        .i_idle_count     (i_idle_count),
        .i_idle_total_us  (i_idle_total_us),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_duration_us    (o_duration_us),
        .o_mean_gap_us    (o_mean_gap_us),
        .o_gap_std_us     (o_gap_std_us),
        .o_idle_mean_us   (o_idle_mean_us),
        .o_idle_fraction  (o_idle_fraction)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // floor square root, one result bit per pass from the top
    function automatic logic [31:0] floor_sqrt(logic [63:0] x);
        logic [31:0] r;
        logic [31:0] t;
        r = '0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (32'd1 << b);
            if (64'(t) * 64'(t) <= x) r = t;
        end
        return r;
    endfunction

    // timing features of one record
    function automatic t_flow_stats flow_stats(t_flow_rec r);
        t_flow_stats s;
        logic [63:0] msq;
        logic [63:0] sq_mean;
        logic [63:0] dur64;
        logic [63:0] qf;
        s.dur   = {1'b0, r.last} - {1'b0, r.first};
        s.mean  = '0;
        s.stdv  = '0;
        s.imean = '0;
        s.frac  = '0;
        if (r.gcnt != 0) begin
            s.mean  = 48'(64'(r.gsum) / 64'(r.gcnt));
            sq_mean = r.gsq / 64'(r.gcnt);
            // mean^2 past 64 bits always beats the mean of squares
            if (s.mean <= 48'hFFFF_FFFF) begin
                msq = 64'(s.mean) * 64'(s.mean);
                if (sq_mean > msq) s.stdv = floor_sqrt(sq_mean - msq);
            end
        end
        if (r.icnt != 0) s.imean = 48'(64'(r.itot) / 64'(r.icnt));
        if (r.last > r.first) begin
            dur64 = 64'(r.last - r.first);
            qf    = {r.itot, 16'h0} / dur64;
            s.frac = (qf > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : qf[31:0];
        end
        return s;
    endfunction

    function automatic logic [47:0] rand48();
        return {16'($urandom), $urandom};
    endfunction

    function automatic t_flow_rec random_record();
        t_flow_rec   r;
        logic [63:0] m;
        int          kind;
        kind = $urandom_range(0, 9);
        if (kind < 2) begin
            // raw noise over every bit
            r.first = rand48();
            r.last  = rand48();
            r.gcnt  = $urandom;
            r.gsum  = rand48();
            r.gsq   = {$urandom, $urandom};
            r.icnt  = $urandom;
            r.itot  = rand48();
        end else begin
            // plausible flow: consistent sums, short duration
            r.first = rand48();
            r.last  = r.first + 48'($urandom_range(0, 2_000_000));
            if (kind == 9) r.last = r.first - 48'($urandom_range(0, 1000));
            r.gcnt  = (kind == 8) ? 32'd0 : 32'($urandom_range(1, 5000));
            m       = 64'($urandom_range(0, 200_000));
            r.gsum  = 48'(64'(r.gcnt) * m + 64'($urandom_range(0, 1000)));
            r.gsq   = 64'(r.gcnt) * (m * m + 64'($urandom_range(0, 50_000_000)));
            if ($urandom_range(0, 7) == 0) r.gsq = r.gsq >> $urandom_range(1, 8);
            r.icnt  = (kind == 7) ? 32'd0 : 32'($urandom_range(1, 300));
            r.itot  = 48'($urandom_range(0, 3_000_000));
        end
        return r;
    endfunction

    // offer one word and hold it until taken
    task automatic send_record(t_flow_rec r, t_flow_stats s);
        i_valid          <= 1'b1;
        i_first_seen_us  <= r.first;
        i_last_seen_us   <= r.last;
        i_gap_count      <= r.gcnt;
        i_gap_sum_us     <= r.gsum;
        i_gap_square_sum <= r.gsq;
        i_idle_count     <= r.icnt;
        i_idle_total_us  <= r.itot;
        do @(posedge i_clk); while (o_stall);
        pending_stats.push_back(s);
    endtask

    task automatic sender_gap(int n);
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // sender
    initial begin
        t_stim_row   rows[$];
        t_stim_row   row;
        t_flow_rec   r;
        logic [47:0] mx48;
        bit          busy_phase;

        mx48 = '1;
        // all zero
        row = '{rec: '{'0, '0, '0, '0, '0, '0, '0}, has_exp: 1'b1,
                exp: '{'0, '0, '0, '0, '0}};
        rows.push_back(row);
        // every field at its top; same timestamps
        row = '{rec: '{mx48, mx48, '1, mx48, '1, '1, mx48}, has_exp: 1'b1,
                exp: '{'0, 48'd65536, 32'd1, 48'd65536, '0}};
        rows.push_back(row);
        // longest positive duration, full idle
        row = '{rec: '{'0, mx48, '0, '0, '0, '0, mx48}, has_exp: 1'b1,
                exp: '{{1'b0, mx48}, '0, '0, '0, 32'h0001_0000}};
        rows.push_back(row);
        // most negative duration: fraction forced to zero
        row = '{rec: '{mx48, '0, '0, '0, '0, '0, mx48}, has_exp: 1'b1,
                exp: '{49'h1_0000_0000_0001, '0, '0, '0, '0}};
        rows.push_back(row);
        // fraction saturates
        row = '{rec: '{'0, 48'd1, '0, '0, '0, '0, mx48}, has_exp: 1'b1,
                exp: '{49'd1, '0, '0, '0, 32'hFFFF_FFFF}};
        rows.push_back(row);
        // variance below zero clamps
        row = '{rec: '{48'd5, 48'd5, 32'd1, 48'd10, 64'd50, '0, '0}, has_exp: 1'b1,
                exp: '{'0, 48'd10, '0, '0, '0}};
        rows.push_back(row);
        // mean squared beyond 64 bits
        row = '{rec: '{'0, '0, 32'd1, 48'h100_0000_0000, '1, '0, '0}, has_exp: 1'b1,
                exp: '{'0, 48'h100_0000_0000, '0, '0, '0}};
        rows.push_back(row);
        // small exact case: variance 16
        row = '{rec: '{48'd100, 48'd200, 32'd4, 48'd20, 64'd164, 32'd2, 48'd50},
                has_exp: 1'b1, exp: '{49'd100, 48'd5, 32'd4, 48'd25, 32'h0000_8000}};
        rows.push_back(row);
        // mean exactly 2^32 - 1 sits on the square limit
        row = '{rec: '{48'd1, 48'd3, 32'd1, 48'hFFFF_FFFF, '1, 32'd3, 48'd7},
                has_exp: 1'b0, exp: '{'0, '0, '0, '0, '0}};
        rows.push_back(row);
        row = '{rec: '{48'd0, 48'd7, 32'd1, 48'h1_0000_0000, '1, '1, 48'd1},
                has_exp: 1'b0, exp: '{'0, '0, '0, '0, '0}};
        rows.push_back(row);
        row = '{rec: '{48'd9, 48'd1000, 32'd3, 48'd3000, 64'd3_100_000, 32'd3, 48'd10},
                has_exp: 1'b0, exp: '{'0, '0, '0, '0, '0}};
        rows.push_back(row);

        repeat (3) @(posedge i_clk);
        foreach (rows[k]) begin
            send_record(rows[k].rec,
                        rows[k].has_exp ? rows[k].exp : flow_stats(rows[k].rec));
            sender_gap($urandom_range(0, 2));
        end

        busy_phase = 1'b0;
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 40 == 0) busy_phase = ($urandom_range(0, 2) == 0);
            // one pause until the pipe has fully drained
            if (n == 350) begin
                sender_gap(1);
                while (pending_stats.size() != 0) @(posedge i_clk);
            end
            r = random_record();
            send_record(r, flow_stats(r));
            sender_gap(busy_phase ? 0 : $urandom_range(0, 10));
        end
        i_valid <= 1'b0;
        sender_done = 1'b1;
    end

    // receiver back-pressure, with one long hold to fill the pipe
    initial begin
        bit held_long;
        bit calm;
        int n_hold;
        held_long = 1'b0;
        calm = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (!held_long && n_results >= 40) begin
                held_long = 1'b1;
                i_stall <= 1'b1;
                repeat (1500) @(posedge i_clk);
            end else begin
                if (n_results % 50 == 0) calm = ($urandom_range(0, 2) == 0);
                n_hold = calm ? 0 : $urandom_range(0, 10);
                if (n_hold > 0) begin
                    i_stall <= 1'b1;
                    repeat (n_hold) @(posedge i_clk);
                end
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_flow_stats e;
        if (i_rst_n && o_valid && !i_stall) begin
            n_results <= n_results + 1;
            if (pending_stats.size() == 0) begin
                $error("unexpected result word");
                n_errors++;
            end else begin
                e = pending_stats.pop_front();
                if (o_duration_us !== e.dur) begin
                    $error("duration_us exp %h got %h", e.dur, o_duration_us);
                    n_errors++;
                end
                if (o_mean_gap_us !== e.mean) begin
                    $error("mean_gap_us exp %h got %h", e.mean, o_mean_gap_us);
                    n_errors++;
                end
                if (o_gap_std_us !== e.stdv) begin
                    $error("gap_std_us exp %h got %h", e.stdv, o_gap_std_us);
                    n_errors++;
                end
                if (o_idle_mean_us !== e.imean) begin
                    $error("idle_mean_us exp %h got %h", e.imean, o_idle_mean_us);
                    n_errors++;
                end
                if (o_idle_fraction !== e.frac) begin
                    $error("idle_fraction exp %h got %h", e.frac, o_idle_fraction);
                    n_errors++;
                end
            end
        end
    end

    // reset, then wait out the run
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (sender_done);
        while (pending_stats.size() != 0) @(posedge i_clk);
        repeat (PIPE_DRAIN) @(posedge i_clk);
        if (n_errors == 0 && pending_stats.size() == 0)
            $display("** flow_timing_statistics_core: PASSED **");
        else
            $display("** flow_timing_statistics_core: FAILED **");
        $finish;
    end

    initial begin
        #5ms;
        $display("** flow_timing_statistics_core: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
